[rtl/aspect_fit_rectangles_defines.svh]
// ---------------------------------------------------------------------------
// aspect_fit_rectangles_defines
// assertion macros shared by the aspect fit rtl
// ---------------------------------------------------------------------------
`ifndef ASPECT_FIT_RECTANGLES_DEFINES_SVH
`define ASPECT_FIT_RECTANGLES_DEFINES_SVH

// implication checked out of reset
`define AFR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked through reset as well
`define AFR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

// next-cycle implication checked out of reset
`define AFR_ASSERT_HOLD(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/afr_pkg.sv]
// ---------------------------------------------------------------------------
// afr_pkg
// fit mode codes for the aspect fit block
// ---------------------------------------------------------------------------
package afr_pkg;

  typedef enum logic [1:0] {
    MODE_STRETCH   = 2'd0,
    MODE_CROP      = 2'd1,
    MODE_LETTERBOX = 2'd2,
    MODE_SMART     = 2'd3
  } fit_sel_t;

  localparam int unsigned SMART_NUM = 11;
  localparam int unsigned SMART_DEN = 10;

endpackage

[rtl/afr_if.sv]
// ---------------------------------------------------------------------------
// afr_in_if / afr_out_if
// request and result channels with valid/ready handshake
// ---------------------------------------------------------------------------
interface afr_in_if #(parameter int DW = 14);
  logic          valid;
  logic          ready;
  logic [DW-1:0] src_w;
  logic [DW-1:0] src_h;
  logic [DW-1:0] tgt_w;
  logic [DW-1:0] tgt_h;
  logic [1:0]    fit_sel;
  modport source (output valid, src_w, src_h, tgt_w, tgt_h, fit_sel, input ready);
  modport sink (input valid, src_w, src_h, tgt_w, tgt_h, fit_sel, output ready);
endinterface

interface afr_out_if #(parameter int DW = 14);
  logic          valid;
  logic          ready;
  logic [DW-1:0] win_x;
  logic [DW-1:0] win_y;
  logic [DW-1:0] win_w;
  logic [DW-1:0] win_h;
  logic [DW-1:0] out_x;
  logic [DW-1:0] out_y;
  logic [DW-1:0] out_w;
  logic [DW-1:0] out_h;
  logic          bad_request;
  modport source (output valid, win_x, win_y, win_w, win_h, out_x, out_y, out_w, out_h,
                  bad_request, input ready);
  modport sink (input valid, win_x, win_y, win_w, win_h, out_x, out_y, out_w, out_h,
                bad_request, output ready);
endinterface

[rtl/aspect_fit_rectangles.sv]
// an accepted request passes stage 1, the divider setup register, the divider stages and the output register
// throughput: one request per cycle unless the output stalls; the divider is DIM_BITS restoring stages
// the whole pipeline holds while a result beat waits and out_ch.ready is low
// reset clears all stage valid bits; payload registers are not reset
// ---------------------------------------------------------------------------
// aspect_fit_rectangles
// pipelined source/destination window calculator for stretch, crop,
// letterbox and smart fit modes
// ---------------------------------------------------------------------------
`include "aspect_fit_rectangles_defines.svh"

module aspect_fit_rectangles #(
  parameter int DIM_BITS = 14
) (
  input  logic      clk,
  input  logic      rst_n,
  afr_in_if.sink    in_ch,
  afr_out_if.source out_ch
);
  import afr_pkg::*;

  localparam int D  = DIM_BITS;
  localparam int PW = 2 * DIM_BITS;
  localparam int SW = 2 * DIM_BITS + 4;

  typedef struct packed {
    logic [D-1:0] sw;
    logic [D-1:0] sh;
    logic [D-1:0] tw;
    logic [D-1:0] th;
    fit_sel_t     mode;
    logic         a_gt_b;
    logic         a_lt_b;
    logic         bad;
  } ctx_t;

  typedef struct packed {
    logic [D-1:0] rem;
    logic [D-1:0] low;
    logic [D-1:0] dvs;
    logic [D-1:0] quo;
  } div_t;

  logic adv;
  assign adv         = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = adv;

  // stage 1: products
  logic         s1_v_r;
  ctx_t         s1_ctx_r;
  logic [PW-1:0] s1_a_r, s1_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= in_ch.valid;
    end
    if (adv) begin
      s1_ctx_r.sw     <= in_ch.src_w;
      s1_ctx_r.sh     <= in_ch.src_h;
      s1_ctx_r.tw     <= in_ch.tgt_w;
      s1_ctx_r.th     <= in_ch.tgt_h;
      s1_ctx_r.mode   <= fit_sel_t'(in_ch.fit_sel);
      s1_ctx_r.a_gt_b <= 1'b0;
      s1_ctx_r.a_lt_b <= 1'b0;
      s1_ctx_r.bad    <= (in_ch.src_w == '0) || (in_ch.src_h == '0) ||
                         (in_ch.tgt_w == '0) || (in_ch.tgt_h == '0);
      s1_a_r <= PW'(in_ch.src_w) * PW'(in_ch.tgt_h);
      s1_b_r <= PW'(in_ch.tgt_w) * PW'(in_ch.src_h);
    end
  end

  // stage 2: mode decision and divider setup
  logic [PW-1:0] hi, lo;
  logic [SW-1:0] hi_x, lo_x;
  logic          a_gt_b, a_lt_b;
  fit_sel_t      mode_eff;
  logic [PW-1:0] dvd;
  logic [D-1:0]  dvs;
  ctx_t          ctx2;

  always_comb begin
    a_gt_b   = s1_a_r > s1_b_r;
    a_lt_b   = s1_a_r < s1_b_r;
    hi       = a_gt_b ? s1_a_r : s1_b_r;
    lo       = a_gt_b ? s1_b_r : s1_a_r;
    hi_x     = SW'(hi) * SW'(SMART_DEN);
    lo_x     = SW'(lo) * SW'(SMART_NUM);
    mode_eff = s1_ctx_r.mode;
    if (s1_ctx_r.mode == MODE_SMART) begin
      if (hi_x <= lo_x) begin
        mode_eff = MODE_STRETCH;
      end else if (!a_gt_b) begin
        mode_eff = MODE_LETTERBOX;
      end else begin
        mode_eff = MODE_CROP;
      end
    end
    dvd = '0;
    dvs = {{(D-1){1'b0}}, 1'b1};
    if (!s1_ctx_r.bad) begin
      case (mode_eff)
        MODE_CROP: begin
          if (a_lt_b) begin
            dvd = s1_a_r;
            dvs = s1_ctx_r.tw;
          end else begin
            dvd = s1_b_r;
            dvs = s1_ctx_r.th;
          end
        end
        MODE_LETTERBOX: begin
          if (a_gt_b) begin
            dvd = s1_b_r;
            dvs = s1_ctx_r.sw;
          end else begin
            dvd = s1_a_r;
            dvs = s1_ctx_r.sh;
          end
        end
        default: begin
          dvd = '0;
        end
      endcase
    end
    ctx2        = s1_ctx_r;
    ctx2.mode   = mode_eff;
    ctx2.a_gt_b = a_gt_b;
    ctx2.a_lt_b = a_lt_b;
  end

  logic [D:0] dv_v_r;
  ctx_t       dv_ctx_r [D+1];
  div_t       dv_r     [D+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_v_r[0] <= 1'b0;
    end else if (adv) begin
      dv_v_r[0] <= s1_v_r;
    end
    if (adv) begin
      dv_ctx_r[0]  <= ctx2;
      dv_r[0].rem  <= dvd[PW-1:D];
      dv_r[0].low  <= dvd[D-1:0];
      dv_r[0].dvs  <= dvs;
      dv_r[0].quo  <= '0;
    end
  end

  // restoring divider, one quotient bit per stage
  for (genvar i = 0; i < D; i++) begin : g_div
    logic [D:0] trial;
    logic       take;
    div_t       nxt;
    always_comb begin
      trial    = {dv_r[i].rem, dv_r[i].low[D-1]} - {1'b0, dv_r[i].dvs};
      take     = !trial[D] || dv_r[i].rem[D-1];
      nxt.dvs  = dv_r[i].dvs;
      nxt.low  = {dv_r[i].low[D-2:0], 1'b0};
      nxt.quo  = {dv_r[i].quo[D-2:0], take};
      nxt.rem  = take ? trial[D-1:0] : {dv_r[i].rem[D-2:0], dv_r[i].low[D-1]};
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_v_r[i+1] <= 1'b0;
      end else if (adv) begin
        dv_v_r[i+1] <= dv_v_r[i];
      end
      if (adv) begin
        dv_ctx_r[i+1] <= dv_ctx_r[i];
        dv_r[i+1]     <= nxt;
      end
    end
  end

  // final stage: rectangles into the output register
  ctx_t         cf;
  logic [D-1:0] q;
  logic [D-1:0] wx_nxt, wy_nxt, ww_nxt, wh_nxt, ox_nxt, oy_nxt, ow_nxt, oh_nxt;

  always_comb begin
    cf     = dv_ctx_r[D];
    q      = dv_r[D].quo;
    wx_nxt = '0;
    wy_nxt = '0;
    ww_nxt = cf.sw;
    wh_nxt = cf.sh;
    ox_nxt = '0;
    oy_nxt = '0;
    ow_nxt = cf.tw;
    oh_nxt = cf.th;
    if (cf.bad) begin
      ww_nxt = '0;
      wh_nxt = '0;
      ow_nxt = '0;
      oh_nxt = '0;
    end else begin
      case (cf.mode)
        MODE_CROP: begin
          ww_nxt = cf.a_lt_b ? cf.sw : q;
          wh_nxt = cf.a_lt_b ? q : cf.sh;
          wx_nxt = (cf.sw - ww_nxt) >> 1;
          wy_nxt = (cf.sh - wh_nxt) >> 1;
        end
        MODE_LETTERBOX: begin
          ow_nxt = cf.a_gt_b ? cf.tw : q;
          oh_nxt = cf.a_gt_b ? q : cf.th;
          ox_nxt = (cf.tw - ow_nxt) >> 1;
          oy_nxt = (cf.th - oh_nxt) >> 1;
        end
        default: begin
          wx_nxt = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_ch.valid <= 1'b0;
    end else if (adv) begin
      out_ch.valid <= dv_v_r[D];
    end
    if (adv) begin
      out_ch.win_x       <= wx_nxt;
      out_ch.win_y       <= wy_nxt;
      out_ch.win_w       <= ww_nxt;
      out_ch.win_h       <= wh_nxt;
      out_ch.out_x       <= ox_nxt;
      out_ch.out_y       <= oy_nxt;
      out_ch.out_w       <= ow_nxt;
      out_ch.out_h       <= oh_nxt;
      out_ch.bad_request <= cf.bad;
    end
  end

  `AFR_ASSERT_NXT(a_rst_idle, !rst_n, !out_ch.valid, "result beat right after reset")
  `AFR_ASSERT_IMP(a_bad_zero, out_ch.valid && out_ch.bad_request,
    out_ch.win_w == '0 && out_ch.win_h == '0 && out_ch.out_w == '0 && out_ch.out_h == '0,
    "rejected request with nonzero rectangle")
  `AFR_ASSERT_IMP(a_ready, 1'b1, in_ch.ready == (!out_ch.valid || out_ch.ready),
    "input ready does not follow output stall")
  `AFR_ASSERT_HOLD(a_hold, out_ch.valid && !out_ch.ready, out_ch.valid && $stable({
    out_ch.win_x, out_ch.win_y, out_ch.win_w, out_ch.win_h, out_ch.out_x, out_ch.out_y,
    out_ch.out_w, out_ch.out_h, out_ch.bad_request}), "result beat changed during stall")

endmodule

[dv/aspect_fit_rectangles_tb_if.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// aspect_fit_rectangles_tb_if
// notes that the block's own request and result interfaces are used directly
// ---------------------------------------------------------------------------
// the channel interfaces afr_in_if and afr_out_if come with the rtl; this file
// only holds the request and result records the test keeps for each accepted beat
package afr_tb_pkg;
  import afr_pkg::*;

  typedef struct packed {
    logic [13:0] src_w;
    logic [13:0] src_h;
    logic [13:0] tgt_w;
    logic [13:0] tgt_h;
    fit_sel_t    mode;
  } fit_req_t;

  typedef struct packed {
    logic [13:0] win_x;
    logic [13:0] win_y;
    logic [13:0] win_w;
    logic [13:0] win_h;
    logic [13:0] out_x;
    logic [13:0] out_y;
    logic [13:0] out_w;
    logic [13:0] out_h;
    logic        bad;
  } fit_rects_t;
endpackage

[dv/aspect_fit_rectangles_test.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// aspect_fit_rectangles_test
// drives directed and random fit requests with random gaps on both channels
// and checks every result beat against a local window calculation
// ---------------------------------------------------------------------------
module aspect_fit_rectangles_test;
  import afr_pkg::*;
  import afr_tb_pkg::*;

  class fit_scoreboard;
    fit_rects_t pending[$];
    int errors;
    int checked;
    int mode_seen[4];
    int rejects;

    function fit_rects_t fit_windows(fit_req_t r);
      fit_rects_t e;
      longint unsigned sw, sh, tw, th, a, b, hi, lo, ww, wh, ow, oh;
      fit_sel_t m;
      sw = r.src_w; sh = r.src_h; tw = r.tgt_w; th = r.tgt_h;
      m = r.mode;
      e = '0;
      if (sw == 0 || sh == 0 || tw == 0 || th == 0) begin
        e.bad = 1'b1;
        return e;
      end
      a = sw * th;
      b = tw * sh;
      if (m == MODE_SMART) begin
        hi = (a > b) ? a : b;
        lo = (a > b) ? b : a;
        if (10 * hi <= 11 * lo) m = MODE_STRETCH;
        else if (a <= b) m = MODE_LETTERBOX;
        else m = MODE_CROP;
      end
      e.win_w = 14'(sw); e.win_h = 14'(sh); e.out_w = 14'(tw); e.out_h = 14'(th);
      if (m == MODE_CROP) begin
        if (a < b) begin
          ww = sw; wh = (sw * th) / tw;
        end else begin
          ww = (sh * tw) / th; wh = sh;
        end
        e.win_x = 14'((sw - ww) / 2); e.win_y = 14'((sh - wh) / 2);
        e.win_w = 14'(ww); e.win_h = 14'(wh);
      end else if (m == MODE_LETTERBOX) begin
        if (a > b) begin
          ow = tw; oh = (tw * sh) / sw;
        end else begin
          ow = (th * sw) / sh; oh = th;
        end
        e.out_x = 14'((tw - ow) / 2); e.out_y = 14'((th - oh) / 2);
        e.out_w = 14'(ow); e.out_h = 14'(oh);
      end
      return e;
    endfunction

    function void note_request(fit_req_t r);
      fit_rects_t e;
      e = fit_windows(r);
      mode_seen[r.mode]++;
      if (e.bad) rejects++;
      pending.push_back(e);
    endfunction

    function void check_field(string name, int exp_v, int act_v);
      if (exp_v != act_v) begin
        $error("%s mismatch: expected %0d actual %0d", name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_result(fit_rects_t got);
      fit_rects_t e;
      if (pending.size() == 0) begin
        $error("result beat with no request outstanding");
        errors++;
        return;
      end
      e = pending.pop_front();
      checked++;
      check_field("win_x", e.win_x, got.win_x);
      check_field("win_y", e.win_y, got.win_y);
      check_field("win_w", e.win_w, got.win_w);
      check_field("win_h", e.win_h, got.win_h);
      check_field("out_x", e.out_x, got.out_x);
      check_field("out_y", e.out_y, got.out_y);
      check_field("out_w", e.out_w, got.out_w);
      check_field("out_h", e.out_h, got.out_h);
      check_field("bad_request", e.bad, got.bad);
    endfunction
  endclass

  localparam int LATENCY = 17;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  bit sending_done = 1'b0;
  fit_scoreboard board;

  afr_in_if #(.DW(14)) in_ch ();
  afr_out_if #(.DW(14)) out_ch ();

  aspect_fit_rectangles #(.DIM_BITS(14)) dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [13:0] rand_dim();
    int p;
    p = $urandom_range(0, 99);
    if (p < 3) return 14'd0;
    if (p < 8) return 14'h3fff;
    if (p < 40) return 14'($urandom_range(1, 64));
    return 14'($urandom_range(1, 16383));
  endfunction

  // valid stays high after the beat unless a gap follows
  task automatic send_request(fit_req_t r);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.src_w <= r.src_w;
    in_ch.src_h <= r.src_h;
    in_ch.tgt_w <= r.tgt_w;
    in_ch.tgt_h <= r.tgt_h;
    in_ch.fit_sel <= r.mode;
    do @(posedge clk); while (!in_ch.ready);
    board.note_request(r);
  endtask

  task automatic send_dims(int sw, int sh, int tw, int th, fit_sel_t m);
    fit_req_t r;
    r.src_w = 14'(sw); r.src_h = 14'(sh); r.tgt_w = 14'(tw); r.tgt_h = 14'(th);
    r.mode = m;
    send_request(r);
  endtask

  task automatic wait_drained();
    while (board.pending.size() != 0) @(posedge clk);
  endtask

  // result side: random stalls, sample at the edge
  initial begin
    fit_rects_t got;
    int stall;
    out_ch.ready <= 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      stall = ($urandom_range(0, 3) == 0) ? gap_len() : 0;
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) begin
        got.win_x = out_ch.win_x; got.win_y = out_ch.win_y;
        got.win_w = out_ch.win_w; got.win_h = out_ch.win_h;
        got.out_x = out_ch.out_x; got.out_y = out_ch.out_y;
        got.out_w = out_ch.out_w; got.out_h = out_ch.out_h;
        got.bad = out_ch.bad_request;
        board.check_result(got);
      end
    end
  end

  initial begin
    fit_req_t r;
    board = new();
    in_ch.valid <= 1'b0;
    in_ch.src_w <= '0;
    in_ch.src_h <= '0;
    in_ch.tgt_w <= '0;
    in_ch.tgt_h <= '0;
    in_ch.fit_sel <= MODE_STRETCH;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: every mode, zero dims, extremes, smart boundaries
    for (int m = 0; m < 4; m++) begin
      send_dims(1920, 1080, 1280, 1024, fit_sel_t'(m));
      send_dims(640, 1080, 1920, 1080, fit_sel_t'(m));
      send_dims(16383, 16383, 1, 16383, fit_sel_t'(m));
      send_dims(1, 16383, 16383, 1, fit_sel_t'(m));
    end
    send_dims(0, 100, 100, 100, MODE_CROP);
    send_dims(100, 0, 100, 100, MODE_SMART);
    send_dims(100, 100, 0, 100, MODE_LETTERBOX);
    send_dims(100, 100, 100, 0, MODE_STRETCH);
    send_dims(110, 100, 100, 100, MODE_SMART);
    send_dims(111, 100, 100, 100, MODE_SMART);
    send_dims(100, 110, 100, 100, MODE_SMART);
    send_dims(100, 111, 100, 100, MODE_SMART);
    send_dims(16383, 16383, 16383, 16383, MODE_SMART);

    // hold off until the pipe is empty
    in_ch.valid <= 1'b0;
    wait_drained();

    for (int i = 0; i < 1000; i++) begin
      if ($urandom_range(0, 3) == 0) begin
        // near-equal aspect ratios around the smart threshold
        r.src_w = 14'($urandom_range(100, 8000));
        r.src_h = 14'($urandom_range(100, 8000));
        r.tgt_w = 14'((int'(r.src_w) * $urandom_range(85, 115)) / 100);
        r.tgt_h = r.src_h;
      end else begin
        r.src_w = rand_dim(); r.src_h = rand_dim();
        r.tgt_w = rand_dim(); r.tgt_h = rand_dim();
      end
      r.mode = fit_sel_t'($urandom_range(0, 3));
      send_request(r);
      if (i == 500) begin
        in_ch.valid <= 1'b0;
        wait_drained();
      end
    end
    in_ch.valid <= 1'b0;
    sending_done = 1'b1;
  end

  initial begin
    wait (sending_done);
    wait_drained();
    repeat (LATENCY * 4) @(posedge clk);
    $display("checked %0d results; modes stretch/crop/letterbox/smart %0d/%0d/%0d/%0d",
             board.checked, board.mode_seen[0], board.mode_seen[1],
             board.mode_seen[2], board.mode_seen[3]);
    $display("zero-dimension requests rejected: %0d", board.rejects);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("Regression FAIL");
    $finish;
  end
endmodule
